@@ rtl/core/uld_pkg.sv @@
// Shared types and constants for the uudecode line checksum block.
package uld_pkg;

    localparam logic [7:0] NEWLINE_CHAR = 8'd10;
    localparam logic [5:0] SIX_OFFSET   = 6'd32;
    localparam int unsigned MAX_RESULTS = 3;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic       checksum_present;
        logic       checksum_bad;
        logic       short_line;
        logic       end_of_data;
        logic       last;
    } result_t;

    // Results caused by one character: count (0..3) and the entries in order.
    typedef struct packed {
        logic [1:0]                   cnt;
        result_t [MAX_RESULTS-1:0]    res;
    } bundle_t;

endpackage

@@ rtl/core/uld_char_if.sv @@
// Valid/ready channel carrying one encoded character per request.
interface uld_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;

    modport source (output valid, output char_in, input ready);
    modport sink   (input valid, input char_in, output ready);
endinterface

@@ rtl/core/uld_res_if.sv @@
// Valid/ready channel carrying one decoded byte or line status per request.
interface uld_res_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] data_byte;
    logic       checksum_present;
    logic       checksum_bad;
    logic       short_line;
    logic       end_of_data;
    logic       last;

    modport source (output valid, output kind, output data_byte, output checksum_present,
                    output checksum_bad, output short_line, output end_of_data,
                    output last, input ready);
    modport sink   (input valid, input kind, input data_byte, input checksum_present,
                    input checksum_bad, input short_line, input end_of_data,
                    input last, output ready);
endinterface

@@ rtl/core/uld_decode.sv @@
// Line state machine: decodes one character into up to three results.
module uld_decode
    import uld_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] char_in,
    input  logic       accept,
    output bundle_t    bundle
);

    typedef enum logic [2:0] {
        PH_LEN   = 3'd0,
        PH_GROUP = 3'd1,
        PH_CHECK = 3'd2,
        PH_SKIP  = 3'd3,
        PH_DONE  = 3'd4
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [5:0]  bytes_left_reg, bytes_left_next;
    logic [17:0] group_chars_reg, group_chars_next;
    logic [1:0]  char_index_reg, char_index_next;
    logic [5:0]  running_sum_reg, running_sum_next;

    logic [5:0]  v;
    logic        is_nl;
    logic [5:0]  ga, gb, gd;
    logic [7:0]  b1, b2, b3;
    logic [1:0]  cnt;
    logic [5:0]  sum6;

    assign v     = char_in[5:0] - SIX_OFFSET;
    assign is_nl = (char_in == NEWLINE_CHAR);
    assign ga    = group_chars_reg[5:0];
    assign gb    = group_chars_reg[11:6];
    assign gd    = group_chars_reg[17:12];
    assign b1    = {ga, gb[5:4]};
    assign b2    = {gb[3:0], gd[5:2]};
    assign b3    = {gd[1:0], v};
    assign sum6  = running_sum_reg + b1[5:0] + b2[5:0] + b3[5:0];
    assign cnt   = (bytes_left_reg < 6'd3) ? bytes_left_reg[1:0] : 2'd3;

    always_comb
    begin
        phase_next       = phase_reg;
        bytes_left_next  = bytes_left_reg;
        group_chars_next = group_chars_reg;
        char_index_next  = char_index_reg;
        running_sum_next = running_sum_reg;
        bundle           = '0;

        case (phase_reg)
            PH_LEN:
            begin
                if (is_nl)
                begin
                    bundle.cnt               = 2'd1;
                    bundle.res[0].kind       = KIND_STATUS;
                    bundle.res[0].short_line = 1'b1;
                    bundle.res[0].last       = 1'b1;
                end
                else if (v == 6'd0)
                begin
                    phase_next                = PH_DONE;
                    bundle.cnt                = 2'd1;
                    bundle.res[0].kind        = KIND_STATUS;
                    bundle.res[0].end_of_data = 1'b1;
                    bundle.res[0].last        = 1'b1;
                end
                else
                begin
                    bytes_left_next  = v;
                    running_sum_next = '0;
                    group_chars_next = '0;
                    char_index_next  = '0;
                    phase_next       = PH_GROUP;
                end
            end
            PH_GROUP:
            begin
                if (is_nl)
                begin
                    // drop the partial group
                    phase_next               = PH_LEN;
                    char_index_next          = '0;
                    group_chars_next         = '0;
                    bundle.cnt               = 2'd1;
                    bundle.res[0].kind       = KIND_STATUS;
                    bundle.res[0].short_line = 1'b1;
                    bundle.res[0].last       = 1'b1;
                end
                else if (char_index_reg != 2'd3)
                begin
                    case (char_index_reg)
                        2'd0:    group_chars_next[5:0]   = v;
                        2'd1:    group_chars_next[11:6]  = v;
                        default: group_chars_next[17:12] = v;
                    endcase
                    char_index_next = char_index_reg + 2'd1;
                end
                else
                begin
                    running_sum_next = sum6;
                    bytes_left_next  = bytes_left_reg - {4'd0, cnt};
                    group_chars_next = '0;
                    char_index_next  = '0;
                    if (bytes_left_reg == {4'd0, cnt})
                    begin
                        phase_next = PH_CHECK;
                    end
                    bundle.cnt               = cnt;
                    bundle.res[0].kind       = KIND_DATA;
                    bundle.res[0].data_byte  = b1;
                    bundle.res[0].last       = (cnt == 2'd1);
                    bundle.res[1].kind       = KIND_DATA;
                    bundle.res[1].data_byte  = b2;
                    bundle.res[1].last       = (cnt == 2'd2);
                    bundle.res[2].kind       = KIND_DATA;
                    bundle.res[2].data_byte  = b3;
                    bundle.res[2].last       = 1'b1;
                end
            end
            PH_CHECK:
            begin
                bundle.cnt         = 2'd1;
                bundle.res[0].kind = KIND_STATUS;
                bundle.res[0].last = 1'b1;
                if (is_nl)
                begin
                    phase_next = PH_LEN;
                end
                else
                begin
                    phase_next                     = PH_SKIP;
                    bundle.res[0].checksum_present = 1'b1;
                    bundle.res[0].checksum_bad     = (v != running_sum_reg);
                end
            end
            PH_SKIP:
            begin
                if (is_nl)
                begin
                    phase_next = PH_LEN;
                end
            end
            default:
            begin
                phase_next = PH_DONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_LEN;
            bytes_left_reg  <= '0;
            group_chars_reg <= '0;
            char_index_reg  <= '0;
            running_sum_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg       <= phase_next;
            bytes_left_reg  <= bytes_left_next;
            group_chars_reg <= group_chars_next;
            char_index_reg  <= char_index_next;
            running_sum_reg <= running_sum_next;
        end
    end

`ifndef ASSERT_OFF
    a_owed_in_group: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_GROUP) |-> (bytes_left_reg != 6'd0))
        else $error("group phase with no bytes owed");

    a_done_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DONE) |=> (phase_reg == PH_DONE))
        else $error("left end-of-data state");

    a_done_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DONE) |-> (bundle.cnt == 2'd0))
        else $error("result after end of data");
`endif

endmodule

@@ rtl/core/uld_serial.sv @@
// Holding register: emits one character's results one per cycle while ready.
module uld_serial
    import uld_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  bundle_t bundle,
    input  logic    load,
    output logic    can_load,
    uld_res_if.source results
);

    result_t [MAX_RESULTS-1:0] res_reg;
    logic       busy_reg, busy_next;
    logic [1:0] idx_reg, idx_next;
    logic [1:0] cnt_reg;
    logic       out_fire;
    logic       at_last;
    result_t    cur;

    assign at_last  = (idx_reg == cnt_reg - 2'd1);
    assign out_fire = busy_reg && results.ready;
    assign can_load = !busy_reg || (out_fire && at_last);

    always_comb
    begin
        case (idx_reg)
            2'd0:    cur = res_reg[0];
            2'd1:    cur = res_reg[1];
            default: cur = res_reg[2];
        endcase
    end

    assign results.valid            = busy_reg;
    assign results.kind             = cur.kind;
    assign results.data_byte        = cur.data_byte;
    assign results.checksum_present = cur.checksum_present;
    assign results.checksum_bad     = cur.checksum_bad;
    assign results.short_line       = cur.short_line;
    assign results.end_of_data      = cur.end_of_data;
    assign results.last             = cur.last;

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (load)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
        end
        else if (out_fire)
        begin
            if (at_last)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
            cnt_reg  <= 2'd1;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
            if (load)
            begin
                cnt_reg <= bundle.cnt;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= bundle.res;
        end
    end

`ifndef ASSERT_OFF
    a_load_safe: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (can_load && bundle.cnt != 2'd0))
        else $error("load over pending results");

    a_load_starts: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (busy_reg && idx_reg == 2'd0))
        else $error("load did not start emission");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (cnt_reg != 2'd0 && idx_reg < cnt_reg))
        else $error("result index out of range");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && results.last && !load) |=> !busy_reg)
        else $error("still busy after last result");
`endif

endmodule

@@ rtl/core/uudecode_line_checksum_top.sv @@
// Top level of the uudecode line checksum decoder.
//
//  channel   dir  payload                                      role
//  chars     in   char_in[7:0]                                 one encoded character
//  results   out  kind, data_byte[7:0], checksum_present,      decoded byte or status
//                 checksum_bad, short_line, end_of_data, last
//
// A character is decoded in the cycle it is accepted; its results leave from a
// holding register from the next cycle on, one per cycle while results is ready.
// A character that causes no result is accepted every cycle; one that causes
// results waits only while earlier results are still pending.
// rst_n clears the line state to expect a length character and empties the
// result register. A stalled results channel holds its request unchanged.
module uudecode_line_checksum_top
    import uld_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    uld_char_if.sink   chars,
    uld_res_if.source  results
);

    bundle_t bundle;
    logic    can_load;
    logic    accept;

    assign chars.ready = can_load || (bundle.cnt == 2'd0);
    assign accept      = chars.valid && chars.ready;

    uld_decode u_decode (
        .clk     (clk),
        .rst_n   (rst_n),
        .char_in (chars.char_in),
        .accept  (accept),
        .bundle  (bundle)
    );

    uld_serial u_serial (
        .clk      (clk),
        .rst_n    (rst_n),
        .bundle   (bundle),
        .load     (accept && (bundle.cnt != 2'd0)),
        .can_load (can_load),
        .results  (results)
    );

endmodule
